[sv/multi_key_press_event_scanner_defines.svh]
// Assertion macros for the key press event scanner.
`ifndef MULTI_KEY_PRESS_EVENT_SCANNER_DEFINES_SVH
`define MULTI_KEY_PRESS_EVENT_SCANNER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MKPES_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MKPES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mkpes_pkg.sv]
// Shared types and constants of the key press event scanner.
`default_nettype none

package mkpes_pkg;

    localparam int NUM_KEYS = 6;
    localparam int KEY_AW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int LEVEL_W  = 6;
    localparam int IDX_W    = 3;
    localparam int KIND_W   = 3;
    localparam int CNT_W    = 16;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;

    localparam logic [CNT_W-1:0] CNT_ONE        = 1;
    localparam logic [CNT_W-1:0] DEBOUNCE_RST   = 2;
    localparam logic [CNT_W-1:0] LONG_PRESS_RST = 100;
    localparam logic [CNT_W-1:0] REPEAT_RST     = 20;

    typedef enum logic [1:0] {
        REG_DEBOUNCE,
        REG_LONG_PRESS,
        REG_REPEAT
    } reg_idx_t;

    typedef enum logic [KIND_W-1:0] {
        EV_PRESS,
        EV_SHORT_RELEASE,
        EV_LONG_PRESS,
        EV_REPEAT,
        EV_LONG_RELEASE
    } ev_kind_t;

    typedef struct packed {
        logic [CNT_W-1:0] debounce_ticks;
        logic [CNT_W-1:0] long_press_ticks;
        logic [CNT_W-1:0] repeat_ticks;
    } cfg_vals_t;

    typedef struct packed {
        logic debounce;
        logic long_press;
        logic rpt;
    } cfg_reload_t;

    typedef struct packed {
        logic [NUM_KEYS-1:0]           mask;
        ev_kind_t [NUM_KEYS-1:0]       kind;
    } ev_rec_t;

    typedef struct packed {
        logic rec_busy;
    } back_stat_t;

endpackage

`default_nettype wire

[sv/multi_key_press_event_scanner.sv]
// Top level of the key press event scanner: register port, front end, queue, back end.
//
// Each input transfer is one scan tick with the pressed level of six keys. Every key steps
// through wait, debounce, long-press wait and auto-repeat in the front end, one tick per
// cycle while the queue is not full; a tick's events go into a two-entry queue and the back
// end sends them one per cycle while out_stall is low, in key order, with last_event set on
// the tick's final event. A tick with no events is not queued and sends nothing. The first
// event of a tick passes through the queue, the back end's record register and its output
// register. in_stall rises only when the queue is full.
// Registers: 0x0 debounce_ticks, 0x4 long_press_ticks, 0x8 repeat_ticks (16 bits each);
// a write reloads the matching counter of every key and must be made while the block is idle.
`default_nettype none
`include "multi_key_press_event_scanner_defines.svh"

module multi_key_press_event_scanner (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mkpes_pkg::ADDR_W-1:0]    paddr,
    input  logic [mkpes_pkg::DATA_W-1:0]    pwdata,
    output logic [mkpes_pkg::DATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [mkpes_pkg::LEVEL_W-1:0]   key_levels,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mkpes_pkg::IDX_W-1:0]     key_index,
    output logic [mkpes_pkg::KIND_W-1:0]    event_kind,
    output logic                            last_event
);
    import mkpes_pkg::*;

    logic [CNT_W-1:0] debounce_ticks_reg;
    logic [CNT_W-1:0] long_press_ticks_reg;
    logic [CNT_W-1:0] repeat_ticks_reg;

    logic             wr_en;
    logic [1:0]       reg_sel;
    cfg_vals_t        cfg;
    cfg_reload_t      reload;
    ev_rec_t          q_wdata;
    ev_rec_t          q_head;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_not_empty;
    back_stat_t       back_stat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];

    assign reload.debounce   = wr_en && (reg_sel == REG_DEBOUNCE);
    assign reload.long_press = wr_en && (reg_sel == REG_LONG_PRESS);
    assign reload.rpt        = wr_en && (reg_sel == REG_REPEAT);

    always_comb
    begin
        case (reg_sel)
            REG_DEBOUNCE:   prdata = DATA_W'(debounce_ticks_reg);
            REG_LONG_PRESS: prdata = DATA_W'(long_press_ticks_reg);
            REG_REPEAT:     prdata = DATA_W'(repeat_ticks_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg   <= DEBOUNCE_RST;
            long_press_ticks_reg <= LONG_PRESS_RST;
            repeat_ticks_reg     <= REPEAT_RST;
        end
        else
        begin
            if (reload.debounce)
                debounce_ticks_reg <= pwdata[CNT_W-1:0];
            if (reload.long_press)
                long_press_ticks_reg <= pwdata[CNT_W-1:0];
            if (reload.rpt)
                repeat_ticks_reg <= pwdata[CNT_W-1:0];
        end
    end

    // reloads take the value being written, not the old register
    assign cfg.debounce_ticks   = reload.debounce   ? pwdata[CNT_W-1:0] : debounce_ticks_reg;
    assign cfg.long_press_ticks = reload.long_press ? pwdata[CNT_W-1:0] : long_press_ticks_reg;
    assign cfg.repeat_ticks     = reload.rpt        ? pwdata[CNT_W-1:0] : repeat_ticks_reg;

    mkpes_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key_levels (key_levels),
        .cfg        (cfg),
        .reload     (reload),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    mkpes_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    mkpes_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .q_not_empty (q_not_empty),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .key_index   (key_index),
        .event_kind  (event_kind),
        .last_event  (last_event),
        .stat        (back_stat)
    );

    `MKPES_ASSERT_SAME(a_more_pending, out_valid && !last_event, back_stat.rec_busy, "event not last but nothing pending")
    `MKPES_ASSERT_NEXT(a_no_gap, out_valid && !out_stall && !last_event, out_valid, "gap inside a tick's events")
    `MKPES_ASSERT_NEXT(a_key_order, out_valid && !out_stall && !last_event, key_index > $past(key_index), "events of a tick out of key order")

endmodule

`default_nettype wire

[sv/mkpes_front.sv]
// Front end: takes scan ticks, steps every key's stage machine, queues the tick's events.
`default_nettype none

module mkpes_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [mkpes_pkg::LEVEL_W-1:0]     key_levels,
    input  mkpes_pkg::cfg_vals_t              cfg,
    input  mkpes_pkg::cfg_reload_t            reload,
    input  logic                              q_full,
    output logic                              q_push,
    output mkpes_pkg::ev_rec_t                q_data
);
    import mkpes_pkg::*;

    typedef enum logic [1:0] {
        ST_WAIT,
        ST_DEBOUNCE,
        ST_LONG,
        ST_REPEAT
    } stage_t;

    stage_t           stage_reg    [NUM_KEYS];
    stage_t           stage_next   [NUM_KEYS];
    logic [CNT_W-1:0] deb_left_reg [NUM_KEYS];
    logic [CNT_W-1:0] deb_left_next[NUM_KEYS];
    logic [CNT_W-1:0] lp_left_reg  [NUM_KEYS];
    logic [CNT_W-1:0] lp_left_next [NUM_KEYS];
    logic [CNT_W-1:0] rp_left_reg  [NUM_KEYS];
    logic [CNT_W-1:0] rp_left_next [NUM_KEYS];

    logic [NUM_KEYS-1:0]     pressed;
    logic [NUM_KEYS-1:0]     fire;
    ev_kind_t [NUM_KEYS-1:0] kind;
    logic                    accept;

    for (genvar g = 0; g < NUM_KEYS; g++)
    begin : g_lvl
        if (g < LEVEL_W)
        begin : g_used
            assign pressed[g] = key_levels[g];
        end
        else
        begin : g_none
            assign pressed[g] = 1'b0;
        end
    end

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            stage_next[k]    = stage_reg[k];
            deb_left_next[k] = deb_left_reg[k];
            lp_left_next[k]  = lp_left_reg[k];
            rp_left_next[k]  = rp_left_reg[k];
            fire[k]          = 1'b0;
            kind[k]          = EV_PRESS;
            case (stage_reg[k])
                ST_WAIT:
                begin
                    if (pressed[k])
                        stage_next[k] = ST_DEBOUNCE;
                end
                ST_DEBOUNCE:
                begin
                    if (pressed[k])
                    begin
                        if (deb_left_reg[k] <= CNT_ONE)
                        begin
                            deb_left_next[k] = cfg.debounce_ticks;
                            stage_next[k]    = ST_LONG;
                            fire[k]          = 1'b1;
                            kind[k]          = EV_PRESS;
                        end
                        else
                            deb_left_next[k] = deb_left_reg[k] - CNT_ONE;
                    end
                    else
                    begin
                        deb_left_next[k] = cfg.debounce_ticks;
                        stage_next[k]    = ST_WAIT;
                    end
                end
                ST_LONG:
                begin
                    if (pressed[k])
                    begin
                        if (lp_left_reg[k] <= CNT_ONE)
                        begin
                            lp_left_next[k] = cfg.long_press_ticks;
                            stage_next[k]   = ST_REPEAT;
                            fire[k]         = 1'b1;
                            kind[k]         = EV_LONG_PRESS;
                        end
                        else
                            lp_left_next[k] = lp_left_reg[k] - CNT_ONE;
                    end
                    else
                    begin
                        lp_left_next[k] = cfg.long_press_ticks;
                        stage_next[k]   = ST_WAIT;
                        fire[k]         = 1'b1;
                        kind[k]         = EV_SHORT_RELEASE;
                    end
                end
                ST_REPEAT:
                begin
                    if (pressed[k])
                    begin
                        if (rp_left_reg[k] <= CNT_ONE)
                        begin
                            rp_left_next[k] = cfg.repeat_ticks;
                            fire[k]         = 1'b1;
                            kind[k]         = EV_REPEAT;
                        end
                        else
                            rp_left_next[k] = rp_left_reg[k] - CNT_ONE;
                    end
                    else
                    begin
                        rp_left_next[k] = cfg.repeat_ticks;
                        stage_next[k]   = ST_WAIT;
                        fire[k]         = 1'b1;
                        kind[k]         = EV_LONG_RELEASE;
                    end
                end
                default:
                begin
                    stage_next[k] = ST_WAIT;
                end
            endcase
        end
    end

    assign q_push      = accept && (|fire);
    assign q_data.mask = fire;
    assign q_data.kind = kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                stage_reg[k]    <= ST_WAIT;
                deb_left_reg[k] <= DEBOUNCE_RST;
                lp_left_reg[k]  <= LONG_PRESS_RST;
                rp_left_reg[k]  <= REPEAT_RST;
            end
        end
        else
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                if (accept)
                    stage_reg[k] <= stage_next[k];
                // register writes reload the matching counters of all keys
                if (reload.debounce)
                    deb_left_reg[k] <= cfg.debounce_ticks;
                else if (accept)
                    deb_left_reg[k] <= deb_left_next[k];
                if (reload.long_press)
                    lp_left_reg[k] <= cfg.long_press_ticks;
                else if (accept)
                    lp_left_reg[k] <= lp_left_next[k];
                if (reload.rpt)
                    rp_left_reg[k] <= cfg.repeat_ticks;
                else if (accept)
                    rp_left_reg[k] <= rp_left_next[k];
            end
        end
    end

endmodule

`default_nettype wire

[sv/mkpes_fifo.sv]
// Short queue of per-tick event records between front and back end.
`default_nettype none

module mkpes_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mkpes_pkg::ev_rec_t   push_data,
    input  logic                 pop,
    output mkpes_pkg::ev_rec_t   head,
    output logic                 full,
    output logic                 not_empty
);
    import mkpes_pkg::*;

    ev_rec_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

[sv/mkpes_back.sv]
// Back end: serializes one tick's events in key order onto the result channel.
`default_nettype none

module mkpes_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mkpes_pkg::ev_rec_t              head,
    input  logic                            q_not_empty,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mkpes_pkg::IDX_W-1:0]     key_index,
    output logic [mkpes_pkg::KIND_W-1:0]    event_kind,
    output logic                            last_event,
    output mkpes_pkg::back_stat_t           stat
);
    import mkpes_pkg::*;

    logic [NUM_KEYS-1:0]     rec_mask_reg;
    logic [NUM_KEYS-1:0]     rec_mask_next;
    ev_kind_t [NUM_KEYS-1:0] rec_kind_reg;
    ev_kind_t [NUM_KEYS-1:0] rec_kind_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [IDX_W-1:0]        key_index_reg;
    logic [IDX_W-1:0]        key_index_next;
    ev_kind_t                event_kind_reg;
    ev_kind_t                event_kind_next;
    logic                    last_event_reg;
    logic                    last_event_next;

    logic                    load;
    logic [KEY_AW-1:0]       sel;
    logic [NUM_KEYS-1:0]     low_bit;
    logic [NUM_KEYS-1:0]     rem_mask;
    logic [NUM_KEYS-1:0]     mask_after;

    assign load = !out_valid_reg || !out_stall;

    always_comb
    begin
        sel     = '0;
        low_bit = '0;
        for (int k = NUM_KEYS - 1; k >= 0; k--)
        begin
            if (rec_mask_reg[k])
            begin
                sel     = KEY_AW'(k);
                low_bit = '0;
                low_bit[k] = 1'b1;
            end
        end
    end

    assign rem_mask   = rec_mask_reg & ~low_bit;
    assign mask_after = load ? rem_mask : rec_mask_reg;
    assign q_pop      = q_not_empty && (mask_after == '0);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        key_index_next  = key_index_reg;
        event_kind_next = event_kind_reg;
        last_event_next = last_event_reg;
        rec_mask_next   = mask_after;
        rec_kind_next   = rec_kind_reg;
        if (load)
        begin
            out_valid_next  = (rec_mask_reg != '0);
            key_index_next  = IDX_W'(sel);
            event_kind_next = rec_kind_reg[sel];
            last_event_next = (rem_mask == '0);
        end
        if (q_pop)
        begin
            rec_mask_next = head.mask;
            rec_kind_next = head.kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rec_mask_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            rec_mask_reg  <= rec_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_index_reg  <= key_index_next;
        event_kind_reg <= event_kind_next;
        last_event_reg <= last_event_next;
        rec_kind_reg   <= rec_kind_next;
    end

    assign out_valid     = out_valid_reg;
    assign key_index     = key_index_reg;
    assign event_kind    = event_kind_reg;
    assign last_event    = last_event_reg;
    assign stat.rec_busy = (rec_mask_reg != '0);

endmodule

`default_nettype wire
